[rtl/core/fswt_pkg.sv]
// ----------------------------------------------------------------------------
// fswt_pkg - shared types and constants of the stall window tracker
// Word formats of both channels, the classified word in the queue and the
// layout of one tracker entry.
// ----------------------------------------------------------------------------
`default_nettype none

package fswt_pkg;

	localparam int unsigned DEF_NUM_PORTS   = 64;
	localparam int unsigned DEF_NUM_CLASSES = 4;

	localparam int unsigned PORT_W    = 6;
	localparam int unsigned CLASS_W   = 2;
	localparam int unsigned COUNT_W   = 64;
	localparam int unsigned PENDING_W = 32;

	localparam int unsigned QUEUE_DEPTH = 2;

	// func codes
	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_RESYNC = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [PORT_W-1:0]  port_index;
		logic [CLASS_W-1:0] class_index;
		logic [COUNT_W-1:0] rx_count;
		logic [COUNT_W-1:0] tx_count;
	} req_t;

	typedef struct packed {
		logic [PENDING_W-1:0] stall_windows;
		logic                 resynced;
	} rsp_t;

	// classified word handed from the front to the back (entry index travels beside it)
	typedef struct packed {
		logic               in_range;
		func_t              func;
		logic [COUNT_W-1:0] rx_count;
		logic [COUNT_W-1:0] tx_count;
	} cls_item_t;

	typedef struct packed {
		logic                 valid;
		logic                 credit;
		logic [PENDING_W-1:0] pending;
		logic [COUNT_W-1:0]   last_tx;
		logic [COUNT_W-1:0]   last_rx;
	} entry_t;

endpackage

`default_nettype wire

[rtl/core/fswt_front.sv]
// ----------------------------------------------------------------------------
// fswt_front - command intake and classification
// Takes a word on start, range-checks port and class, forms the entry index
// and holds the classified word until the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module fswt_front
	import fswt_pkg::*;
#(
	parameter int unsigned NUM_PORTS   = DEF_NUM_PORTS,
	parameter int unsigned NUM_CLASSES = DEF_NUM_CLASSES,
	parameter int unsigned IDX_W       = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire req_t             req,
	output      logic             busy,
	input  wire logic             clearing,
	input  wire logic             q_full,
	output      logic             push,
	output      cls_item_t        push_item,
	output      logic [IDX_W-1:0] push_idx
);

	logic             accept;
	logic             fv_q;
	cls_item_t        item_q;
	logic [IDX_W-1:0] idx_q;
	logic             in_range;
	logic [31:0]      flat_idx;

	assign busy   = clearing || (fv_q && q_full);
	assign accept = start && !busy;
	assign push   = fv_q && !q_full;

	assign in_range = (32'(req.port_index) < 32'(NUM_PORTS)) &&
	                  (32'(req.class_index) < 32'(NUM_CLASSES));
	assign flat_idx = 32'(req.port_index) * 32'(NUM_CLASSES) + 32'(req.class_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= 1'b0;
		end else if (accept) begin
			fv_q <= 1'b1;
		end else if (push) begin
			fv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.in_range <= in_range;
			item_q.func     <= req.func;
			item_q.rx_count <= req.rx_count;
			item_q.tx_count <= req.tx_count;
			idx_q           <= flat_idx[IDX_W-1:0];
		end
	end

	assign push_item = item_q;
	assign push_idx  = idx_q;

endmodule

`default_nettype wire

[rtl/core/fswt_queue.sv]
// ----------------------------------------------------------------------------
// fswt_queue - short word queue between front and back
// Small flop FIFO; decouples intake stalls from table work.
// ----------------------------------------------------------------------------
`default_nettype none

module fswt_queue
	import fswt_pkg::*;
#(
	parameter int unsigned WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output      logic             full,
	input  wire logic             pop,
	output      logic             head_valid,
	output      logic [WIDTH-1:0] head_data
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/core/fswt_back.sv]
// ----------------------------------------------------------------------------
// fswt_back - entry table read-modify-write
// Clears the table after reset, then pops one word a cycle, reads its entry,
// applies the sample/resync rules and writes back, forwarding the last write.
// ----------------------------------------------------------------------------
`default_nettype none

module fswt_back
	import fswt_pkg::*;
#(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned IDX_W = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	output      logic             clearing,
	input  wire logic             head_valid,
	input  wire cls_item_t        head_item,
	input  wire logic [IDX_W-1:0] head_idx,
	output      logic             pop,
	output      logic             done,
	output      rsp_t             rsp
);

	entry_t           ent_mem [DEPTH];
	logic             clr_q;
	logic [IDX_W-1:0] clr_cnt_q;

	logic             v_s1;
	cls_item_t        item_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rdata_s1;
	logic             fwd_hit_s1;
	entry_t           fwd_s1;

	entry_t           cur;
	entry_t           nxt;
	rsp_t             res;
	logic             wr_en;
	logic             resync;
	logic             rx_act;
	logic             tx_act;
	logic             had_pend;
	logic [PENDING_W-1:0] pend_inc;

	logic             done_q;
	rsp_t             rsp_q;

	assign clearing = clr_q;
	assign pop      = head_valid && !clr_q;

	// entry as seen after the write still in flight
	assign cur = fwd_hit_s1 ? fwd_s1 : rdata_s1;

	always_comb begin
		resync   = (item_s1.func == FUNC_RESYNC) || !cur.valid ||
		           (item_s1.rx_count < cur.last_rx) || (item_s1.tx_count < cur.last_tx);
		rx_act   = (item_s1.rx_count != cur.last_rx);
		tx_act   = (item_s1.tx_count != cur.last_tx);
		had_pend = (cur.pending != '0);
		pend_inc = (cur.pending == '1) ? cur.pending : cur.pending + 1'b1;

		nxt.valid   = 1'b1;
		nxt.last_rx = item_s1.rx_count;
		nxt.last_tx = item_s1.tx_count;
		nxt.pending = '0;
		nxt.credit  = 1'b0;

		if (resync) begin
			nxt.pending = '0;
			nxt.credit  = 1'b0;
		end else if (had_pend) begin
			if (cur.credit || tx_act) begin
				nxt.credit = tx_act;
			end else begin
				nxt.pending = pend_inc;
			end
		end else if (rx_act) begin
			if (cur.credit) begin
				nxt.credit = tx_act;
			end else if (tx_act) begin
				nxt.credit = 1'b1;
			end else begin
				nxt.pending = PENDING_W'(1);
			end
		end else begin
			nxt.credit = tx_act;
		end

		wr_en = v_s1 && item_s1.in_range;
		if (item_s1.in_range) begin
			res.stall_windows = nxt.pending;
			res.resynced      = resync;
		end else begin
			res.stall_windows = '0;
			res.resynced      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_cnt_q  <= '0;
			v_s1       <= 1'b0;
			fwd_hit_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (clr_q) begin
				if (clr_cnt_q == IDX_W'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			v_s1       <= pop;
			fwd_hit_s1 <= wr_en && pop && (idx_s1 == head_idx);
			done_q     <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head_item;
			idx_s1  <= head_idx;
		end
		fwd_s1   <= nxt;
		rdata_s1 <= ent_mem[head_idx];
		rsp_q    <= res;
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			ent_mem[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			ent_mem[idx_s1] <= nxt;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

[rtl/core/flow_stall_window_tracker.sv]
// ----------------------------------------------------------------------------
// flow_stall_window_tracker - per-port, per-class stall window tracker
// Keeps one entry per (port, class) and counts consecutive windows of
// received but unanswered traffic from periodic counter samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a word on req is taken at a rising edge with start high
//    and busy low. func selects sample or resync of the addressed entry.
//  - Result channel: done is high for exactly one cycle with rsp carrying
//    stall_windows and the resynced flag; one result word per command, in
//    command order. The receiver cannot stall, so the back end never waits.
//  - Path: from the accepting edge a command passes the front register, a
//    queue slot, the table read and the update/result register to done.
//  - Throughput: one command per cycle sustained outside the table sweep.
//    The table RMW is a registered read plus an update; the write still in
//    flight is forwarded, so back-to-back hits on one entry need no bubble.
//  - Reset: arst_n clears control state, then the back end sweeps the table,
//    one entry a cycle, NUM_PORTS*NUM_CLASSES entries (256 by default),
//    with busy held high. After that every entry reads uninitialised, so its
//    first sample resyncs it.
//  - Ports or classes beyond the table give stall_windows 0, resynced 0 and
//    leave the table untouched.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_stall_window_tracker
	import fswt_pkg::*;
#(
	parameter int unsigned NUM_PORTS   = DEF_NUM_PORTS,
	parameter int unsigned NUM_CLASSES = DEF_NUM_CLASSES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output      logic busy,
	output      logic done,
	output      rsp_t rsp
);

	localparam int unsigned DEPTH = NUM_PORTS * NUM_CLASSES;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned Q_W   = $bits(cls_item_t) + IDX_W;

	logic             clearing;
	logic             q_full;
	logic             push;
	cls_item_t        push_item;
	logic [IDX_W-1:0] push_idx;
	logic             pop;
	logic             head_valid;
	logic [Q_W-1:0]   head_data;
	cls_item_t        head_item;
	logic [IDX_W-1:0] head_idx;

	// front: intake and classification
	fswt_front #(
		.NUM_PORTS   (NUM_PORTS),
		.NUM_CLASSES (NUM_CLASSES),
		.IDX_W       (IDX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item),
		.push_idx  (push_idx)
	);

	// queue word: entry index on top, classified word below
	fswt_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_idx, push_item}),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign head_item = head_data[$bits(cls_item_t)-1:0];
	assign head_idx  = head_data[Q_W-1:$bits(cls_item_t)];

	// back: table clear, read-modify-write, result register
	fswt_back #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_idx   (head_idx),
		.pop        (pop),
		.done       (done),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire
